[rtl/ictf_pkg.sv]
// Shared widths, constants, register codes and arctangent table of the tilt filter.
package ictf_pkg;

    localparam int FRAC_BITS     = 16;
    localparam int RAW_W         = 16;
    localparam int MS_W          = 16;
    localparam int CFG_W         = 26;
    localparam int BAND_W        = 25;
    localparam int OUT_W         = 26;
    localparam int CFG_IDX_W     = 3;
    localparam int S_DATA_W      = 112;
    localparam int M_DATA_W      = 160;

    localparam int ANUM_W        = RAW_W + 1;
    localparam int SQ_W          = 2 * RAW_W;
    localparam int SQRT_SHIFT    = 28;
    localparam int ROOT_W        = (SQ_W + SQRT_SHIFT) / 2;
    localparam int CORDIC_STEPS  = 24;
    localparam int STEP_W        = $clog2(CORDIC_STEPS);
    localparam int CORD_W        = ROOT_W + 3;
    localparam int ANG_W         = 25;
    localparam int TAB_W         = 23;
    localparam int Y_SCALE       = 14;

    localparam int RATE_DIV      = 131;
    localparam int RATE_HALF     = 65;
    localparam int RATE_NUM_W    = RAW_W + FRAC_BITS;
    localparam int RATE_W        = CFG_W + 1;

    localparam int MS_DIV        = 1000;
    localparam int MS_HALF       = 500;
    localparam int PROD_W        = OUT_W + MS_W;

    localparam int ACC_W         = CFG_W + 1;
    localparam int ACCB_W        = 32;
    localparam int BLEND_DIV     = 25;
    localparam int BLEND_HALF    = 12;
    localparam int BLEND_BIAS_EXP = 27;

    localparam int LIM360        = 360 << FRAC_BITS;
    localparam int DEG90         = 90 << FRAC_BITS;

    localparam logic signed [CFG_W-1:0] RST_BIAS_X   = 26'sd62915;
    localparam logic signed [CFG_W-1:0] RST_BIAS_Y   = -26'sd32702464;
    localparam logic signed [CFG_W-1:0] RST_BIAS_Z   = 26'sd17039;
    localparam logic [BAND_W-1:0]       RST_BAND_X   = 25'd458752;
    localparam logic [BAND_W-1:0]       RST_BAND_Y   = 25'd327680;
    localparam logic [BAND_W-1:0]       RST_BAND_Z   = 25'd196608;
    localparam logic signed [CFG_W-1:0] RST_OFS_ROLL  = -26'sd38011;
    localparam logic signed [CFG_W-1:0] RST_OFS_PITCH = 26'sd103547;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BIAS_X    = 3'd0,
        REG_BIAS_Y    = 3'd1,
        REG_BIAS_Z    = 3'd2,
        REG_BAND_X    = 3'd3,
        REG_BAND_Y    = 3'd4,
        REG_BAND_Z    = 3'd5,
        REG_OFS_ROLL  = 3'd6,
        REG_OFS_PITCH = 3'd7
    } cfg_reg_t;

    function automatic logic [TAB_W-1:0] atan_tab(input logic [STEP_W-1:0] idx);
        logic [TAB_W-1:0] v;
        case (idx)
            5'd0:    v = 23'd2949120;
            5'd1:    v = 23'd1740967;
            5'd2:    v = 23'd919879;
            5'd3:    v = 23'd466945;
            5'd4:    v = 23'd234379;
            5'd5:    v = 23'd117304;
            5'd6:    v = 23'd58666;
            5'd7:    v = 23'd29335;
            5'd8:    v = 23'd14668;
            5'd9:    v = 23'd7334;
            5'd10:   v = 23'd3667;
            5'd11:   v = 23'd1833;
            5'd12:   v = 23'd917;
            5'd13:   v = 23'd458;
            5'd14:   v = 23'd229;
            5'd15:   v = 23'd115;
            5'd16:   v = 23'd57;
            5'd17:   v = 23'd29;
            5'd18:   v = 23'd14;
            5'd19:   v = 23'd7;
            5'd20:   v = 23'd4;
            5'd21:   v = 23'd2;
            5'd22:   v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

[rtl/ictf_sdiv.sv]
// Bit-serial restoring divider of an unsigned word by a fixed small divisor.
module ictf_sdiv #(
    parameter int DVD_W   = 32,
    parameter int DIVISOR = 131
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    localparam int REM_W = $clog2(DIVISOR + 1);
    localparam int CNT_W = $clog2(DVD_W + 1);
    localparam logic [REM_W:0] DIV_C = (REM_W + 1)'(DIVISOR);

    logic [DVD_W-1:0] work_reg, work_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W:0]   trial;
    logic             fits;

    always_comb begin
        trial     = {rem_reg, work_reg[DVD_W-1]};
        fits      = (trial >= DIV_C);
        work_next = work_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            work_next = dividend;
            rem_next  = '0;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            work_next = {work_reg[DVD_W-2:0], fits};
            rem_next  = fits ? REM_W'(trial - DIV_C) : trial[REM_W-1:0];
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        rem_reg  <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = work_reg;

endmodule

[rtl/ictf_atan.sv]
// Tilt angle unit: squares, bit-serial square root and serial CORDIC vectoring.
module ictf_atan
    import ictf_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic signed [ANUM_W-1:0] num,
    input  logic signed [RAW_W-1:0]  den_a,
    input  logic signed [RAW_W-1:0]  den_b,
    output logic                     done,
    output logic signed [ANG_W-1:0]  angle
);
    typedef enum logic [3:0] {
        AT_IDLE   = 4'b0001,
        AT_SUM    = 4'b0010,
        AT_ROOT   = 4'b0100,
        AT_ROTATE = 4'b1000
    } at_state_t;

    localparam int CNT_W  = $clog2(ROOT_W + 1);
    localparam int RREM_W = ROOT_W + 3;
    localparam logic signed [ANG_W-1:0] ANG90 = ANG_W'(DEG90);

    at_state_t                 state_reg, state_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic                      done_reg, done_next;
    logic [SQ_W-2:0]           sqa_reg, sqa_next, sqb_reg, sqb_next;
    logic signed [ANUM_W-1:0]  num_reg, num_next;
    logic [SQ_W-1:0]           rad_reg, rad_next;
    logic [RREM_W-1:0]         rem_reg, rem_next;
    logic [ROOT_W-1:0]         root_reg, root_next;
    logic signed [CORD_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic signed [ANG_W-1:0]   z_reg, z_next, angle_reg, angle_next;

    logic signed [SQ_W-1:0]    sqa_full, sqb_full;
    logic [SQ_W-1:0]           sum_sq;
    logic [RREM_W-1:0]         rem_try, root_try;
    logic                      root_fits;
    logic [ROOT_W-1:0]         root_step;
    logic signed [CORD_W-1:0]  dx, dy;
    logic signed [ANG_W-1:0]   tab, z_step;

    assign sqa_full = den_a * den_a;
    assign sqb_full = den_b * den_b;

    always_comb begin
        sum_sq    = SQ_W'(sqa_reg) + SQ_W'(sqb_reg);
        rem_try   = {rem_reg[RREM_W-3:0], rad_reg[SQ_W-1 -: 2]};
        root_try  = {1'b0, root_reg, 2'b01};
        root_fits = (rem_try >= root_try);
        root_step = {root_reg[ROOT_W-2:0], root_fits};
        dx        = y_reg >>> cnt_reg[STEP_W-1:0];
        dy        = x_reg >>> cnt_reg[STEP_W-1:0];
        tab       = ANG_W'(atan_tab(cnt_reg[STEP_W-1:0]));
        z_step    = (y_reg > 0) ? z_reg + tab : z_reg - tab;

        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        sqa_next   = sqa_reg;
        sqb_next   = sqb_reg;
        num_next   = num_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        angle_next = angle_reg;

        unique case (state_reg)
            AT_IDLE: begin
                if (start) begin
                    sqa_next   = sqa_full[SQ_W-2:0];
                    sqb_next   = sqb_full[SQ_W-2:0];
                    num_next   = num;
                    state_next = AT_SUM;
                end
            end
            AT_SUM: begin
                if (sum_sq == '0) begin
                    if (num_reg > 0) begin
                        angle_next = ANG90;
                    end else if (num_reg < 0) begin
                        angle_next = -ANG90;
                    end else begin
                        angle_next = '0;
                    end
                    done_next  = 1'b1;
                    state_next = AT_IDLE;
                end else if (num_reg == '0) begin
                    angle_next = '0;
                    done_next  = 1'b1;
                    state_next = AT_IDLE;
                end else begin
                    rad_next   = sum_sq;
                    rem_next   = '0;
                    root_next  = '0;
                    cnt_next   = CNT_W'(ROOT_W);
                    state_next = AT_ROOT;
                end
            end
            AT_ROOT: begin
                rad_next  = {rad_reg[SQ_W-3:0], 2'b00};
                rem_next  = root_fits ? rem_try - root_try : rem_try;
                root_next = root_step;
                cnt_next  = cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    x_next     = CORD_W'(root_step);
                    y_next     = CORD_W'($signed({num_reg, {Y_SCALE{1'b0}}}));
                    z_next     = '0;
                    cnt_next   = '0;
                    state_next = AT_ROTATE;
                end
            end
            AT_ROTATE: begin
                if (y_reg > 0) begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                end else begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                end
                z_next   = z_step;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CORDIC_STEPS - 1)) begin
                    angle_next = z_step;
                    done_next  = 1'b1;
                    state_next = AT_IDLE;
                end
            end
            default: state_next = AT_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= AT_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sqa_reg   <= sqa_next;
        sqb_reg   <= sqb_next;
        num_reg   <= num_next;
        rad_reg   <= rad_next;
        rem_reg   <= rem_next;
        root_reg  <= root_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        z_reg     <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

[rtl/imu_complementary_tilt_filter.sv]
// Top level of the complementary tilt filter: sequencer, integrators and item ports.
//
//  channel | direction | fields (lowest bit first)
//  --------+-----------+-----------------------------------------------------------
//  s_      | in        | accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
//  m_      | out       | roll_deg, pitch_deg, yaw_deg, rate_x, rate_y, rate_z
//  cfg_    | in        | cfg_index selects the register, cfg_wdata is written
//
// A new item is accepted only when the sequencer is idle, after the last one has finished.
// The square root and CORDIC loop set the front half, which is shorter when both angles
// take the zero shortcut, then follow the divide by 1000 and the blend divide by 25.
// A stalled result holds the final step until taken.
// Reset clears the integrators and loads the register defaults.
// A finished result waits in the output register while the next item is taken.
module imu_complementary_tilt_filter
    import ictf_pkg::*;
#(
    parameter int INTEGRAL_WIDTH = 48
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, elapsed_ms
    input  logic [S_DATA_W-1:0]  s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // roll_deg, pitch_deg, yaw_deg, rate_x, rate_y, rate_z, zero fill
    output logic [M_DATA_W-1:0]  m_tdata,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);
    localparam int IW    = INTEGRAL_WIDTH;
    localparam int SAT_W = ((IW > PROD_W) ? IW : PROD_W) + 1;
    localparam int BL_W  = IW + 5;
    localparam int YAW_W = PROD_W + 2;

    localparam logic [IW-1:0]           INT_MAX  = {1'b0, {(IW - 1){1'b1}}};
    localparam logic [BL_W-1:0]         BL_K     = BL_W'(1) << BLEND_BIAS_EXP;
    localparam logic [BL_W-1:0]         BL_LO    = BL_K - BL_W'(LIM360);
    localparam logic [BL_W-1:0]         BL_HI    = BL_K + BL_W'(LIM360);
    localparam logic [ACCB_W+1:0]       ACC_OFS  =
        ((ACCB_W + 2)'(BLEND_DIV) << BLEND_BIAS_EXP) + (ACCB_W + 2)'(BLEND_HALF);
    localparam logic signed [YAW_W-1:0] YAW_LIM  = YAW_W'(LIM360);
    localparam logic signed [YAW_W-1:0] YAW_NLIM = -YAW_LIM;
    localparam logic signed [OUT_W-1:0] OUT_LIM  = OUT_W'(LIM360);
    localparam logic signed [OUT_W-1:0] OUT_NLIM = -OUT_LIM;

    typedef enum logic [11:0] {
        ST_IDLE  = 12'b000000000001,
        ST_START = 12'b000000000010,
        ST_FRONT = 12'b000000000100,
        ST_RATE  = 12'b000000001000,
        ST_BAND  = 12'b000000010000,
        ST_MUL   = 12'b000000100000,
        ST_INCGO = 12'b000001000000,
        ST_INC   = 12'b000010000000,
        ST_INTEG = 12'b000100000000,
        ST_BLGO  = 12'b001000000000,
        ST_BLEND = 12'b010000000000,
        ST_FIN   = 12'b100000000000
    } state_t;

    state_t                    state_reg, state_next;
    logic [2:0]                flags_reg, flags_next;
    logic                      m_valid_reg, m_valid_next;

    logic signed [CFG_W-1:0]   bias_reg [3];
    logic [BAND_W-1:0]         band_reg [3];
    logic signed [CFG_W-1:0]   ofs_roll_reg, ofs_pitch_reg;

    logic signed [RAW_W-1:0]   ax_reg, ay_reg, az_reg;
    logic signed [RAW_W-1:0]   gyro_reg [3];
    logic [MS_W-1:0]           ms_reg;

    logic signed [RATE_W-1:0]  r_reg [3];
    logic signed [RATE_W-1:0]  r_next [3];
    logic [OUT_W-1:0]          rate_reg [3];
    logic [OUT_W-1:0]          rate_next [3];
    logic [PROD_W-1:0]         prod_reg [3];
    logic [PROD_W-1:0]         prod_next [3];
    logic [PROD_W-1:0]         mul [3];
    logic signed [ACC_W-1:0]   acc_reg [2];
    logic signed [ACC_W-1:0]   acc_next [2];
    logic [ACCB_W-1:0]         accb_reg [2];
    logic [ACCB_W-1:0]         accb_next [2];
    logic [ACCB_W+1:0]         accb_wide [2];

    logic [IW-1:0]             roll_int_reg, roll_int_next;
    logic [IW-1:0]             pitch_int_reg, pitch_int_next;
    logic signed [OUT_W-1:0]   yaw_reg, yaw_next;

    logic [OUT_W-1:0]          out_roll_reg, out_roll_next;
    logic [OUT_W-1:0]          out_pitch_reg, out_pitch_next;
    logic [OUT_W-1:0]          out_yaw_reg, out_yaw_next;
    logic [OUT_W-1:0]          out_rate_reg [3];
    logic [OUT_W-1:0]          out_rate_next [3];

    logic                      accept;
    logic                      front_go, inc_go, blend_go;
    logic [RAW_W:0]            gmag [3];
    logic [RATE_NUM_W-1:0]     rate_dvd [3];
    logic [RATE_NUM_W-1:0]     rate_q [3];
    logic                      rate_done [3];
    logic [PROD_W-1:0]         inc_q [3];
    logic                      inc_done [3];
    logic [BL_W-1:0]           bl_dvd [2];
    logic [BL_W-1:0]           bl_q [2];
    logic                      bl_done [2];
    logic                      roll_done, pitch_done;
    logic signed [ANG_W-1:0]   roll_ang, pitch_ang;
    logic signed [ANUM_W-1:0]  roll_num, pitch_num;
    logic [SAT_W-1:0]          roll_sum, pitch_sum;
    logic signed [YAW_W-1:0]   yaw_sum;
    logic                      roll_ok, pitch_ok;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign front_go  = (state_reg == ST_START);
    assign inc_go    = (state_reg == ST_INCGO);
    assign blend_go  = (state_reg == ST_BLGO);
    assign roll_num  = ANUM_W'(ay_reg);
    assign pitch_num = -ANUM_W'(ax_reg);

    ictf_atan u_atan_roll (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (front_go),
        .num     (roll_num),
        .den_a   (ax_reg),
        .den_b   (az_reg),
        .done    (roll_done),
        .angle   (roll_ang)
    );

    ictf_atan u_atan_pitch (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (front_go),
        .num     (pitch_num),
        .den_a   (ay_reg),
        .den_b   (az_reg),
        .done    (pitch_done),
        .angle   (pitch_ang)
    );

    for (genvar k = 0; k < 3; k++) begin : g_axis
        ictf_sdiv #(
            .DVD_W   (RATE_NUM_W),
            .DIVISOR (RATE_DIV)
        ) u_rate_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (front_go),
            .dividend (rate_dvd[k]),
            .done     (rate_done[k]),
            .quotient (rate_q[k])
        );

        ictf_sdiv #(
            .DVD_W   (PROD_W),
            .DIVISOR (MS_DIV)
        ) u_inc_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (inc_go),
            .dividend (prod_reg[k]),
            .done     (inc_done[k]),
            .quotient (inc_q[k])
        );
    end

    for (genvar j = 0; j < 2; j++) begin : g_tilt
        ictf_sdiv #(
            .DVD_W   (BL_W),
            .DIVISOR (BLEND_DIV)
        ) u_blend_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (blend_go),
            .dividend (bl_dvd[j]),
            .done     (bl_done[j]),
            .quotient (bl_q[j])
        );
    end

    assign bl_dvd[0] = (BL_W'(roll_int_reg) << 4) + (BL_W'(roll_int_reg) << 3)
                     + BL_W'(accb_reg[0]);
    assign bl_dvd[1] = (BL_W'(pitch_int_reg) << 4) + (BL_W'(pitch_int_reg) << 3)
                     + BL_W'(accb_reg[1]);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            gmag[k]      = gyro_reg[k][RAW_W-1] ? ~{1'b1, gyro_reg[k]} + 1'b1
                                                : {1'b0, gyro_reg[k]};
            rate_dvd[k]  = RATE_NUM_W'({gmag[k], {FRAC_BITS{1'b0}}})
                         + RATE_NUM_W'(RATE_HALF);
            r_next[k]    = (gyro_reg[k][RAW_W-1] ? -RATE_W'(rate_q[k]) : RATE_W'(rate_q[k]))
                         + RATE_W'(bias_reg[k]);
            rate_next[k] = (r_reg[k] < $signed({2'b00, band_reg[k]})) ? '0
                         : OUT_W'(r_reg[k] - $signed({2'b00, band_reg[k]}));
            mul[k]       = rate_reg[k] * ms_reg;
            prod_next[k] = mul[k] + PROD_W'(MS_HALF);
        end
        acc_next[0]  = ACC_W'(roll_ang) + ACC_W'(ofs_roll_reg);
        acc_next[1]  = ACC_W'(pitch_ang) + ACC_W'(ofs_pitch_reg);
        for (int j = 0; j < 2; j++) begin
            accb_wide[j] = (ACCB_W + 2)'(acc_reg[j]) + ACC_OFS;
            accb_next[j] = accb_wide[j][ACCB_W-1:0];
        end
    end

    always_comb begin
        roll_sum  = SAT_W'(roll_int_reg) + SAT_W'(inc_q[0]);
        pitch_sum = SAT_W'(pitch_int_reg) + SAT_W'(inc_q[1]);
        yaw_sum   = YAW_W'(yaw_reg) + YAW_W'(inc_q[2]);
        roll_ok   = (bl_q[0] >= BL_LO) && (bl_q[0] <= BL_HI);
        pitch_ok  = (bl_q[1] >= BL_LO) && (bl_q[1] <= BL_HI);

        state_next     = state_reg;
        flags_next     = flags_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        roll_int_next  = roll_int_reg;
        pitch_int_next = pitch_int_reg;
        yaw_next       = yaw_reg;
        out_roll_next  = out_roll_reg;
        out_pitch_next = out_pitch_reg;
        out_yaw_next   = out_yaw_reg;
        out_rate_next  = out_rate_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_START;
                end
            end
            ST_START: begin
                flags_next = '0;
                state_next = ST_FRONT;
            end
            ST_FRONT: begin
                flags_next = flags_reg | {pitch_done, roll_done,
                                          rate_done[0] & rate_done[1] & rate_done[2]};
                if (&flags_next) begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:  state_next = ST_BAND;
            ST_BAND:  state_next = ST_MUL;
            ST_MUL:   state_next = ST_INCGO;
            ST_INCGO: state_next = ST_INC;
            ST_INC: begin
                if (inc_done[0] && inc_done[1] && inc_done[2]) begin
                    state_next = ST_INTEG;
                end
            end
            ST_INTEG: begin
                roll_int_next  = (roll_sum > SAT_W'(INT_MAX)) ? INT_MAX : roll_sum[IW-1:0];
                pitch_int_next = (pitch_sum > SAT_W'(INT_MAX)) ? INT_MAX : pitch_sum[IW-1:0];
                yaw_next       = (yaw_sum > YAW_LIM || yaw_sum < YAW_NLIM) ? '0
                               : OUT_W'(yaw_sum);
                state_next     = ST_BLGO;
            end
            ST_BLGO:  state_next = ST_BLEND;
            ST_BLEND: begin
                if (bl_done[0] && bl_done[1]) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!m_valid_reg || m_tready) begin
                    out_roll_next  = roll_ok ? OUT_W'(bl_q[0] - BL_K) : '0;
                    out_pitch_next = pitch_ok ? OUT_W'(bl_q[1] - BL_K) : '0;
                    out_yaw_next   = yaw_reg;
                    out_rate_next  = rate_reg;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            flags_reg     <= '0;
            m_valid_reg   <= 1'b0;
            roll_int_reg  <= '0;
            pitch_int_reg <= '0;
            yaw_reg       <= '0;
            bias_reg[0]   <= RST_BIAS_X;
            bias_reg[1]   <= RST_BIAS_Y;
            bias_reg[2]   <= RST_BIAS_Z;
            band_reg[0]   <= RST_BAND_X;
            band_reg[1]   <= RST_BAND_Y;
            band_reg[2]   <= RST_BAND_Z;
            ofs_roll_reg  <= RST_OFS_ROLL;
            ofs_pitch_reg <= RST_OFS_PITCH;
        end else begin
            state_reg     <= state_next;
            flags_reg     <= flags_next;
            m_valid_reg   <= m_valid_next;
            roll_int_reg  <= roll_int_next;
            pitch_int_reg <= pitch_int_next;
            yaw_reg       <= yaw_next;
            if (cfg_we) begin
                unique case (cfg_reg_t'(cfg_index))
                    REG_BIAS_X:    bias_reg[0]   <= cfg_wdata;
                    REG_BIAS_Y:    bias_reg[1]   <= cfg_wdata;
                    REG_BIAS_Z:    bias_reg[2]   <= cfg_wdata;
                    REG_BAND_X:    band_reg[0]   <= cfg_wdata[BAND_W-1:0];
                    REG_BAND_Y:    band_reg[1]   <= cfg_wdata[BAND_W-1:0];
                    REG_BAND_Z:    band_reg[2]   <= cfg_wdata[BAND_W-1:0];
                    REG_OFS_ROLL:  ofs_roll_reg  <= cfg_wdata;
                    REG_OFS_PITCH: ofs_pitch_reg <= cfg_wdata;
                    default:       ofs_pitch_reg <= ofs_pitch_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ax_reg      <= s_tdata[15:0];
            ay_reg      <= s_tdata[31:16];
            az_reg      <= s_tdata[47:32];
            gyro_reg[0] <= s_tdata[63:48];
            gyro_reg[1] <= s_tdata[79:64];
            gyro_reg[2] <= s_tdata[95:80];
            ms_reg      <= s_tdata[111:96];
        end
        if (state_reg == ST_RATE) begin
            r_reg   <= r_next;
            acc_reg <= acc_next;
        end
        if (state_reg == ST_BAND) begin
            rate_reg <= rate_next;
            accb_reg <= accb_next;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
        out_roll_reg  <= out_roll_next;
        out_pitch_reg <= out_pitch_next;
        out_yaw_reg   <= out_yaw_next;
        out_rate_reg  <= out_rate_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 6 * OUT_W){1'b0}}, out_rate_reg[2], out_rate_reg[1],
                       out_rate_reg[0], out_yaw_reg, out_pitch_reg, out_roll_reg};

    a_yaw_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (yaw_reg <= OUT_LIM) && (yaw_reg >= OUT_NLIM))
        else $error("yaw integral left its range");

    a_int_sign: assert property (@(posedge aclk) disable iff (!aresetn)
        !roll_int_reg[IW-1] && !pitch_int_reg[IW-1])
        else $error("integrator went negative");

    a_rate_when: assert property (@(posedge aclk) disable iff (!aresetn)
        rate_done[0] |-> (state_reg == ST_FRONT))
        else $error("rate divider finished outside the front phase");

    a_load_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result loaded outside the final step");

endmodule

[tb/sv/imu_complementary_tilt_filter_tb.sv]
// Testbench of the complementary tilt filter: directed and random samples checked against a predictor.
module imu_complementary_tilt_filter_tb;
    import ictf_pkg::*;

    typedef struct packed {
        logic [OUT_W-1:0] rz;
        logic [OUT_W-1:0] ry;
        logic [OUT_W-1:0] rx;
        logic [OUT_W-1:0] yaw;
        logic [OUT_W-1:0] pitch;
        logic [OUT_W-1:0] roll;
    } tilt_out_t;

    localparam int IW = 48;
    localparam longint ATAN_DEG16 [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [S_DATA_W-1:0] s_tdata = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    logic [CFG_W-1:0] regs [8];
    longint roll_int, pitch_int, yaw_int;
    tilt_out_t expected_q[$];
    int errors = 0;
    int burst_left = 0;
    bit stall_free = 1'b0;

    always #5 aclk = ~aclk;

    imu_complementary_tilt_filter u_top (.*);

    function automatic longint fl_shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic longint tilt_angle(longint num, longint unsigned sq);
        longint x, y, z = 0, dx, dy;
        if (sq == 0) return (num > 0) ? DEG90 : (num < 0) ? -DEG90 : 0;
        if (num == 0) return 0;
        x = isqrt(sq << 28);
        y = num * 16384;
        for (int i = 0; i < 24; i++) begin
            dx = fl_shr(y, i);
            dy = fl_shr(x, i);
            if (y > 0) begin
                x += dx; y -= dy; z += ATAN_DEG16[i];
            end else begin
                x -= dx; y += dy; z -= ATAN_DEG16[i];
            end
        end
        return z;
    endfunction

    function automatic longint corrected_rate(logic signed [15:0] raw,
                                              logic signed [CFG_W-1:0] bias,
                                              logic [BAND_W-1:0] band);
        longint v = longint'(raw) * 65536;
        longint q = (v >= 0) ? (v + 65) / 131 : -((-v + 65) / 131);
        longint r = q + longint'(bias);
        longint t = longint'(band);
        return (r < t) ? 0 : r - t;
    endfunction

    function automatic longint sat_sum(longint a, longint d);
        longint lim = (64'sd1 <<< (IW - 1)) - 1;
        return (a > lim - d) ? lim : a + d;
    endfunction

    function automatic longint floor25(longint t);
        longint q = t / 25;
        if (t % 25 != 0 && t < 0) q--;
        return q;
    endfunction

    function automatic longint blend_angle(longint integ, longint acc);
        return 24 * (integ / 25) + floor25(24 * (integ % 25) + acc + 12);
    endfunction

    function automatic longint clip360(longint v);
        return (v > LIM360 || v < -LIM360) ? 0 : v;
    endfunction

    function automatic tilt_out_t predict_tilt(logic [S_DATA_W-1:0] d);
        logic signed [15:0] ax, ay, az;
        longint ms, racc, pacc, rx, ry, rz;
        tilt_out_t o;
        ax = d[15:0]; ay = d[31:16]; az = d[47:32];
        ms = longint'(d[111:96]);
        racc = tilt_angle(ay, longint'(ax) * ax + longint'(az) * az)
               + longint'($signed(regs[REG_OFS_ROLL]));
        pacc = tilt_angle(-longint'(ax), longint'(ay) * ay + longint'(az) * az)
               + longint'($signed(regs[REG_OFS_PITCH]));
        rx = corrected_rate(d[63:48], regs[REG_BIAS_X], regs[REG_BAND_X][BAND_W-1:0]);
        ry = corrected_rate(d[79:64], regs[REG_BIAS_Y], regs[REG_BAND_Y][BAND_W-1:0]);
        rz = corrected_rate(d[95:80], regs[REG_BIAS_Z], regs[REG_BAND_Z][BAND_W-1:0]);
        roll_int = sat_sum(roll_int, (rx * ms + 500) / 1000);
        pitch_int = sat_sum(pitch_int, (ry * ms + 500) / 1000);
        yaw_int = clip360(yaw_int + (rz * ms + 500) / 1000);
        o.roll = OUT_W'(clip360(blend_angle(roll_int, racc)));
        o.pitch = OUT_W'(clip360(blend_angle(pitch_int, pacc)));
        o.yaw = OUT_W'(yaw_int);
        o.rx = OUT_W'(rx); o.ry = OUT_W'(ry); o.rz = OUT_W'(rz);
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [OUT_W-1:0] got, logic [OUT_W-1:0] exp);
        $display("mismatch %s: got %0d expected %0d", what, got, exp);
        errors++;
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        regs[idx] = (idx >= REG_BAND_X && idx <= REG_BAND_Z) ? {1'b0, val[BAND_W-1:0]} : val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic wait_drained();
        if (burst_left != 0) begin
            s_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (expected_q.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic send_sample(logic [S_DATA_W-1:0] d);
        if (burst_left == 0) begin
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = $urandom_range(1, 8);
        end
        s_tvalid <= 1'b1;
        s_tdata <= d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_q.push_back(predict_tilt(d));
        burst_left--;
        if (burst_left == 0) s_tvalid <= 1'b0;
    endtask

    function automatic logic [15:0] raw_word();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'($signed($urandom_range(0, 400)) - 200);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [S_DATA_W-1:0] random_sample();
        logic [15:0] ms;
        ms = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 50));
        return {ms, raw_word(), raw_word(), raw_word(), raw_word(), raw_word(), raw_word()};
    endfunction

    task automatic test_directed();
        logic [15:0] ext [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
        send_sample('0);
        send_sample({16'd10, 48'd0, 16'd0, 16'd100, 16'd0});
        send_sample({16'd10, 48'd0, 16'd0, 16'hFF9C, 16'd0});
        send_sample({16'd10, 48'd0, 16'd16384, 16'd0, 16'd0});
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                send_sample({16'hFFFF, {3{ext[j]}}, ext[i], ext[j], ext[(i + j) % 4]});
        send_sample({16'd65535, {3{16'h7FFF}}, 16'd100, 16'd0, 16'd16384});
        send_sample({16'd65535, {3{16'h8000}}, 16'd0, 16'd0, 16'd16384});
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_reg(REG_BIAS_X, 26'h1FFFFFF);
        write_reg(REG_BIAS_Y, 26'h2000000);
        write_reg(REG_BIAS_Z, 26'h1FFFFFF);
        write_reg(REG_BAND_X, 26'd0);
        write_reg(REG_BAND_Y, 26'h1FFFFFF);
        write_reg(REG_BAND_Z, 26'd0);
        write_reg(REG_OFS_ROLL, 26'(23592960));
        write_reg(REG_OFS_PITCH, 26'(-23592960));
        repeat (20) send_sample(random_sample());
        wait_drained();
        write_reg(REG_BIAS_X, 26'h2000000);
        write_reg(REG_BIAS_Z, 26'h2000000);
        write_reg(REG_BAND_Z, 26'h1FFFFFF);
        write_reg(REG_OFS_ROLL, 26'(-23592960));
        write_reg(REG_OFS_PITCH, 26'(23592960));
        repeat (20) send_sample(random_sample());
        wait_drained();
    endtask

    task automatic test_random();
        for (int phase = 0; phase < 5; phase++) begin
            for (int r = 0; r < 8; r++) begin
                case (r)
                    0, 1, 2: write_reg(cfg_reg_t'(r), 26'($signed($urandom_range(0, 600000)) - 300000));
                    3, 4, 5: write_reg(cfg_reg_t'(r), 26'($urandom_range(0, 500000)));
                    default: write_reg(cfg_reg_t'(r), 26'($signed($urandom_range(0, 4000000)) - 2000000));
                endcase
            end
            if (phase == 4) write_reg(REG_BAND_X, 26'h1FFFFFF);
            repeat (380) send_sample(random_sample());
            wait_drained();
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_free = ~stall_free;
            m_tready <= stall_free || ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        tilt_out_t got, exp;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[6*OUT_W-1:0];
            if (expected_q.size() == 0) begin
                $display("unexpected result item");
                errors++;
            end else begin
                exp = expected_q.pop_front();
                if (got.roll !== exp.roll) report_mismatch("roll_deg", got.roll, exp.roll);
                if (got.pitch !== exp.pitch) report_mismatch("pitch_deg", got.pitch, exp.pitch);
                if (got.yaw !== exp.yaw) report_mismatch("yaw_deg", got.yaw, exp.yaw);
                if (got.rx !== exp.rx) report_mismatch("rate_x", got.rx, exp.rx);
                if (got.ry !== exp.ry) report_mismatch("rate_y", got.ry, exp.ry);
                if (got.rz !== exp.rz) report_mismatch("rate_z", got.rz, exp.rz);
            end
        end
    end

    initial begin
        regs[REG_BIAS_X] = RST_BIAS_X;
        regs[REG_BIAS_Y] = RST_BIAS_Y;
        regs[REG_BIAS_Z] = RST_BIAS_Z;
        regs[REG_BAND_X] = RST_BAND_X;
        regs[REG_BAND_Y] = RST_BAND_Y;
        regs[REG_BAND_Z] = RST_BAND_Z;
        regs[REG_OFS_ROLL] = RST_OFS_ROLL;
        regs[REG_OFS_PITCH] = RST_OFS_PITCH;
        roll_int = 0;
        pitch_int = 0;
        yaw_int = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_config_extremes();
        test_random();
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("Some tests failed");
        $finish;
    end

endmodule
